// File: design/cic_pkg.sv
// ----------------------------------------------------------------------------
// cic_pkg - shared types and constants of the CIC filter
// Register indexes, default sizes and the configuration bundle handed from
// the register block to the filter engine.
// ----------------------------------------------------------------------------
package cic_pkg;

  localparam int unsigned MAX_STAGES_DEF = 8;
  localparam int unsigned MAX_RATE_DEF   = 64;
  localparam int unsigned ACC_WIDTH_DEF  = 32;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned QDEPTH   = 2;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_STAGES    = 3'd1;
  localparam logic [2:0] REG_DIFFDELAY = 3'd2;
  localparam logic [2:0] REG_RATE      = 3'd3;
  localparam logic [2:0] REG_NORMALIZE = 3'd4;

  // Effective (saturated) configuration.
  typedef struct packed {
    logic       mode;   // 0 decimate, 1 interpolate
    logic       m2;     // differential delay is two
    logic       norm;   // divide results by the gain
    logic [4:0] n;      // stages, 1..MAX_STAGES
    logic [6:0] r;      // rate, 1..MAX_RATE
  } cfg_t;

endpackage

// File: design/cic_front.sv
// ----------------------------------------------------------------------------
// cic_front - input queue of the CIC filter
// Accepts sample beats and holds them in a short queue until the filter
// engine takes them.
// ----------------------------------------------------------------------------
module cic_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cic_pkg::SAMPLE_W-1:0]  sample_in_i,
  output logic                          q_valid_o,
  output logic [cic_pkg::SAMPLE_W-1:0]  q_sample_o,
  input  logic                          q_pop_i
);

  logic [cic_pkg::SAMPLE_W-1:0] mem_q [cic_pkg::QDEPTH];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o = (cnt_q == 2'(cic_pkg::QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_sample_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= sample_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      case ({push, q_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: design/cic_core.sv
// ----------------------------------------------------------------------------
// cic_core - filter engine of the CIC filter
// Walks integrator and comb stages one per cycle, normalizes through a
// bit-serial divider and holds the result in an output register.
// ----------------------------------------------------------------------------
module cic_core #(
  parameter int unsigned MAX_STAGES = cic_pkg::MAX_STAGES_DEF,
  parameter int unsigned ACC_WIDTH  = cic_pkg::ACC_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cic_pkg::cfg_t                 cfg_i,
  input  logic                          restart_i,
  input  logic                          q_valid_i,
  input  logic [cic_pkg::SAMPLE_W-1:0]  q_sample_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cic_pkg::SAMPLE_W-1:0]  sample_out_o,
  output logic                          last_of_run_o
);

  localparam int unsigned SIW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int unsigned CD  = 2 * MAX_STAGES;
  localparam int unsigned CIW = $clog2(CD);
  localparam int unsigned DCW = $clog2(ACC_WIDTH);
  localparam int unsigned AW  = ACC_WIDTH;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_INTEG = 6'b000100,
    S_COMB  = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e         state_q, state_d;
  logic [AW-1:0]  sum_q, sum_d;
  logic [SIW-1:0] stg_q, stg_d;
  logic [6:0]     rep_q, rep_d;
  logic [5:0]     dph_q, dph_d;
  logic           cph_q, cph_d;
  logic [AW-1:0]  integ_q [MAX_STAGES];
  logic [AW-1:0]  integ_d [MAX_STAGES];
  logic [AW-1:0]  comb_q [CD];
  logic [AW-1:0]  comb_d [CD];
  logic [AW-1:0]  ddiv_q, ddiv_d, idiv_q, idiv_d;
  logic [AW-1:0]  rem_q, rem_d, quo_q, quo_d;
  logic           neg_q, neg_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic           ov_q, ov_d, last_q, last_d;
  logic [AW-1:0]  res_q, res_d;

  logic           stg_last, out_free, rep_last;
  logic [7:0]     rm;
  logic [AW+7:0]  pd_prod, pi_prod;
  logic [AW-1:0]  acc_in, integ_sum, comb_dv, finish_v;
  logic [CIW-1:0] cidx;
  logic [AW:0]    dt, dv;
  logic           dge;
  logic [AW-1:0]  dq;

  assign stg_last = (5'(stg_q) == (cfg_i.n - 5'd1));
  assign rep_last = (rep_q == (cfg_i.r - 7'd1));
  assign out_free = !ov_q || !out_stall_i;
  assign rm       = cfg_i.m2 ? {cfg_i.r, 1'b0} : {1'b0, cfg_i.r};
  assign pd_prod  = (AW+8)'(ddiv_q) * (AW+8)'(rm);
  assign pi_prod  = (AW+8)'(ddiv_q) * (AW+8)'({6'd0, cfg_i.m2, ~cfg_i.m2});
  assign acc_in   = AW'($signed(q_sample_i));
  assign integ_sum = sum_q + integ_q[stg_q];
  assign cidx     = CIW'((cfg_i.m2 ? {1'b0, stg_q, 1'b0} : {2'b00, stg_q})
                         + (SIW+2)'(cph_q));
  assign comb_dv  = comb_q[cidx];
  assign dt       = {rem_q, quo_q[AW-1]};
  assign dv       = {1'b0, (cfg_i.mode ? idiv_q : ddiv_q)};
  assign dge      = (dt >= dv);
  assign dq       = {quo_q[AW-2:0], dge};

  assign q_pop_o       = (state_q == S_IDLE) && q_valid_i && !restart_i;
  assign out_valid_o   = ov_q;
  assign sample_out_o  = cic_pkg::SAMPLE_W'($signed(res_q));
  assign last_of_run_o = last_q;

  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    stg_d   = stg_q;
    rep_d   = rep_q;
    dph_d   = dph_q;
    cph_d   = cph_q;
    integ_d = integ_q;
    comb_d  = comb_q;
    ddiv_d  = ddiv_q;
    idiv_d  = idiv_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    dcnt_d  = dcnt_q;
    ov_d    = ov_q && out_stall_i;
    last_d  = last_q;
    res_d   = res_q;
    finish_v = sum_q;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          sum_d   = acc_in;
          stg_d   = '0;
          rep_d   = '0;
          state_d = cfg_i.mode ? S_COMB : S_INTEG;
        end
      end
      S_SETUP: begin
        if (stg_last) begin
          idiv_d  = (|pi_prod[AW+7:AW]) ? '1 : pi_prod[AW-1:0];
          stg_d   = '0;
          state_d = S_IDLE;
        end else begin
          stg_d = stg_q + SIW'(1);
        end
        ddiv_d = (|pd_prod[AW+7:AW]) ? '1 : pd_prod[AW-1:0];
      end
      S_INTEG: begin
        integ_d[stg_q] = integ_sum;
        sum_d          = integ_sum;
        finish_v       = integ_sum;
        if (stg_last) begin
          stg_d = '0;
          if (!cfg_i.mode) begin
            if (dph_q != 6'd0) begin
              dph_d   = dph_q - 6'd1;
              state_d = S_IDLE;
            end else begin
              dph_d   = 6'(cfg_i.r - 7'd1);
              state_d = S_COMB;
            end
          end else begin
            state_d = cfg_i.norm ? S_DIV : S_OUT;
          end
        end else begin
          stg_d = stg_q + SIW'(1);
        end
      end
      S_COMB: begin
        comb_d[cidx] = sum_q;
        sum_d        = sum_q - comb_dv;
        finish_v     = sum_q - comb_dv;
        if (stg_last) begin
          stg_d = '0;
          if (cfg_i.m2) cph_d = ~cph_q;
          if (!cfg_i.mode) begin
            state_d = cfg_i.norm ? S_DIV : S_OUT;
          end else begin
            state_d = S_INTEG;
          end
        end else begin
          stg_d = stg_q + SIW'(1);
        end
      end
      S_DIV: begin
        rem_d  = dge ? AW'(dt - dv) : AW'(dt);
        quo_d  = dq;
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(AW - 1)) begin
          sum_d   = neg_q ? (AW'(0) - dq) : dq;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ov_d   = 1'b1;
          res_d  = sum_q;
          last_d = cfg_i.mode ? rep_last : 1'b1;
          if (!cfg_i.mode || rep_last) begin
            state_d = S_IDLE;
          end else begin
            rep_d   = rep_q + 7'd1;
            sum_d   = '0;
            stg_d   = '0;
            state_d = S_INTEG;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Arm the divider with the magnitude of the value that just finished.
    if (state_d == S_DIV && state_q != S_DIV) begin
      neg_d  = finish_v[AW-1];
      quo_d  = finish_v[AW-1] ? (AW'(0) - finish_v) : finish_v;
      rem_d  = '0;
      dcnt_d = '0;
    end

    // A register write restarts the filter and recomputes the divisors.
    if (restart_i) begin
      for (int i = 0; i < MAX_STAGES; i++) integ_d[i] = '0;
      for (int i = 0; i < CD; i++) comb_d[i] = '0;
      cph_d   = 1'b0;
      dph_d   = '0;
      stg_d   = '0;
      ddiv_d  = AW'(1);
      idiv_d  = AW'(1);
      state_d = S_SETUP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stg_q   <= '0;
      rep_q   <= '0;
      dph_q   <= '0;
      cph_q   <= 1'b0;
      for (int i = 0; i < MAX_STAGES; i++) integ_q[i] <= '0;
      for (int i = 0; i < CD; i++) comb_q[i] <= '0;
      ddiv_q  <= AW'(1);
      idiv_q  <= AW'(1);
      dcnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      stg_q   <= stg_d;
      rep_q   <= rep_d;
      dph_q   <= dph_d;
      cph_q   <= cph_d;
      integ_q <= integ_d;
      comb_q  <= comb_d;
      ddiv_q  <= ddiv_d;
      idiv_q  <= idiv_d;
      dcnt_q  <= dcnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
    last_q <= last_d;
    res_q  <= res_d;
  end

endmodule

// File: design/cic_decimate_interpolate.sv
// ----------------------------------------------------------------------------
// cic_decimate_interpolate - CIC decimator / interpolator
// Register block, input queue and filter engine of a cascaded
// integrator-comb filter with optional gain normalization.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                                   | Direction
//   --------+-------------------------------------------+----------
//   input   | in_valid_i, in_stall_o, sample_in_i       | in
//   output  | out_valid_o, out_stall_i, sample_out_o,   | out
//           | last_of_run_o                             |
//   config  | psel_i, penable_i, pwrite_i, paddr_i,     | in
//           | pwdata_i, prdata_o, pready_o              |
//
// The engine walks one stage per cycle. A decimate beat that is dropped
// runs only the integrators, a kept one the integrators and combs and,
// with normalization, the bit-serial divider. An interpolate beat runs
// the combs, then R rounds of integrators, each followed by the divider
// with normalization. Reset clears all filter state; divisors start at
// one. A register write clears the state and recomputes the divisors.
// The two-entry input queue takes beats until it is full while the engine
// works, and the output register holds a result while the engine moves on.
//
module cic_decimate_interpolate #(
  parameter int unsigned MAX_STAGES = cic_pkg::MAX_STAGES_DEF,
  parameter int unsigned MAX_RATE   = cic_pkg::MAX_RATE_DEF,
  parameter int unsigned ACC_WIDTH  = cic_pkg::ACC_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cic_pkg::SAMPLE_W-1:0]  sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cic_pkg::SAMPLE_W-1:0]  sample_out_o,
  output logic                          last_of_run_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [4:0]                    paddr_i,
  input  logic [31:0]                   pwdata_i,
  output logic [31:0]                   prdata_o,
  output logic                          pready_o
);

  logic       mode_q, norm_q;
  logic [3:0] stages_q;
  logic [1:0] delay_q;
  logic [6:0] rate_q;
  logic       wr_en, wr_hit;
  logic [2:0] ridx;

  cic_pkg::cfg_t              cfg;
  logic                       q_valid, q_pop;
  logic [cic_pkg::SAMPLE_W-1:0] q_sample;

  assign pready_o = 1'b1;
  assign ridx     = paddr_i[4:2];
  assign wr_en    = psel_i && penable_i && pwrite_i;

  // Only writes that land on a register restart the filter.
  always_comb begin
    unique case (ridx)
      cic_pkg::REG_MODE:      begin wr_hit = wr_en; prdata_o = {31'd0, mode_q}; end
      cic_pkg::REG_STAGES:    begin wr_hit = wr_en; prdata_o = {28'd0, stages_q}; end
      cic_pkg::REG_DIFFDELAY: begin wr_hit = wr_en; prdata_o = {30'd0, delay_q}; end
      cic_pkg::REG_RATE:      begin wr_hit = wr_en; prdata_o = {25'd0, rate_q}; end
      cic_pkg::REG_NORMALIZE: begin wr_hit = wr_en; prdata_o = {31'd0, norm_q}; end
      default:                begin wr_hit = 1'b0;  prdata_o = 32'd0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      stages_q <= 4'd1;
      delay_q  <= 2'd1;
      rate_q   <= 7'd1;
      norm_q   <= 1'b0;
    end else if (wr_hit) begin
      unique case (ridx)
        cic_pkg::REG_MODE:      mode_q   <= pwdata_i[0];
        cic_pkg::REG_STAGES:    stages_q <= pwdata_i[3:0];
        cic_pkg::REG_DIFFDELAY: delay_q  <= pwdata_i[1:0];
        cic_pkg::REG_RATE:      rate_q   <= pwdata_i[6:0];
        cic_pkg::REG_NORMALIZE: norm_q   <= pwdata_i[0];
        default:                mode_q   <= mode_q;
      endcase
    end
  end

  // Out-of-range settings saturate into their ranges.
  always_comb begin
    cfg.mode = mode_q;
    cfg.norm = norm_q;
    cfg.m2   = (delay_q >= 2'd2);
    if (stages_q == 4'd0) cfg.n = 5'd1;
    else if (5'(stages_q) > 5'(MAX_STAGES)) cfg.n = 5'(MAX_STAGES);
    else cfg.n = 5'(stages_q);
    if (rate_q == 7'd0) cfg.r = 7'd1;
    else if (rate_q > 7'(MAX_RATE)) cfg.r = 7'(MAX_RATE);
    else cfg.r = rate_q;
  end

  cic_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .q_valid_o   (q_valid),
    .q_sample_o  (q_sample),
    .q_pop_i     (q_pop)
  );

  cic_core #(
    .MAX_STAGES (MAX_STAGES),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .restart_i     (wr_hit),
    .q_valid_i     (q_valid),
    .q_sample_i    (q_sample),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_out_o  (sample_out_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
